// ===== sv/pfpt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame pin table package
// Payload types, command and status codes, and controller/datapath links.
// ----------------------------------------------------------------------------
package pfpt_pkg;

   localparam int FRAME_COUNT_DEF = 16;
   localparam int PIN_BITS_DEF    = 16;

   localparam logic [2:0] CMD_FETCH = 3'd0;
   localparam logic [2:0] CMD_NEW   = 3'd1;
   localparam logic [2:0] CMD_UNPIN = 3'd2;
   localparam logic [2:0] CMD_FLUSH = 3'd3;
   localparam logic [2:0] CMD_QUERY = 3'd4;

   localparam logic [2:0] STAT_OK       = 3'd0;
   localparam logic [2:0] STAT_FULL     = 3'd1;
   localparam logic [2:0] STAT_NOTRES   = 3'd2;
   localparam logic [2:0] STAT_UNPINNED = 3'd3;
   localparam logic [2:0] STAT_IOERR    = 3'd4;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [31:0] page_id;
      logic [31:0] new_page_id;
      logic        mark_dirty;
      logic        io_ok;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  frame_index;
      logic [31:0] result_page;
      logic [15:0] pin_value;
      logic        resident;
      logic        disk_read;
      logic        disk_write;
   } rsp_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LOOKUP,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic capture;
      logic lookup;
      logic exec;
   } ctrl_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_stat_type;

endpackage
`default_nettype wire

// ===== sv/pfpt_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pfpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== sv/pfpt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame pin table controller
// Sequences capture, lookup and execute of one transaction at a time.
// ----------------------------------------------------------------------------
module pfpt_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire pfpt_pkg::dp_stat_type dp_stat,
   output pfpt_pkg::ctrl_cmd_type     ctl_cmd
);
   import pfpt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: begin
            state_in = S_EXEC;
         end
         S_EXEC: begin
            if (dp_stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      req_stall       = 1'b1;
      ctl_cmd.capture = 1'b0;
      ctl_cmd.lookup  = 1'b0;
      ctl_cmd.exec    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_stall       = 1'b0;
            ctl_cmd.capture = req_valid;
         end
         S_LOOKUP: begin
            ctl_cmd.lookup = 1'b1;
         end
         S_EXEC: begin
            ctl_cmd.exec = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule
`default_nettype wire

// ===== sv/pfpt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame pin table datapath
// Request register, page match cells, free count, pin/dirty RAM, result register.
// ----------------------------------------------------------------------------
module pfpt_dp #(
   parameter int FRAME_COUNT = 16,
   parameter int PIN_BITS    = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire pfpt_pkg::ctrl_cmd_type ctl_cmd,
   output pfpt_pkg::dp_stat_type       dp_stat,
   input  wire pfpt_pkg::req_type      req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output pfpt_pkg::rsp_type           rsp_data
);
   import pfpt_pkg::*;

   localparam int IDX_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1;
   localparam int CNT_W = $clog2(FRAME_COUNT + 1);

   req_type                req_ff;
   logic [31:0]            page_ff [FRAME_COUNT];
   logic [FRAME_COUNT-1:0] valid_ff;
   logic [FRAME_COUNT-1:0] match_ff;
   logic                   hit_ff;
   logic [IDX_W-1:0]       hit_idx_ff;
   logic [CNT_W-1:0]       count_ff;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   rsp_type                rsp_ff;

   logic [31:0]            key_w;
   logic [FRAME_COUNT-1:0] match_w;
   logic [IDX_W-1:0]       hit_idx_w;
   logic                   out_free_w;
   logic                   commit_w;
   logic                   full_w;
   logic [IDX_W-1:0]       alloc_idx_w;
   logic                   alloc_w;
   logic [FRAME_COUNT-1:0] inval_w;
   logic                   wr_en_w;
   logic [IDX_W-1:0]       wr_addr_w;
   logic [PIN_BITS:0]      wr_data_w;
   logic [IDX_W-1:0]       rd_addr_w;
   logic [PIN_BITS:0]      rd_data_w;
   logic [PIN_BITS-1:0]    rd_pins_w;
   logic                   rd_dirty_w;
   logic [PIN_BITS-1:0]    new_pins_w;
   rsp_type                rsp_w;

   pfpt_ram #(
      .WIDTH (PIN_BITS + 1),
      .DEPTH (FRAME_COUNT)
   ) u_pin_ram (
      .clock   (clock),
      .wr_en   (wr_en_w),
      .wr_addr (wr_addr_w),
      .wr_data (wr_data_w),
      .rd_addr (rd_addr_w),
      .rd_data (rd_data_w)
   );

   assign key_w      = (req_ff.cmd == CMD_NEW) ? req_ff.new_page_id : req_ff.page_id;
   assign out_free_w = !rsp_valid_ff || !rsp_stall;
   assign commit_w   = ctl_cmd.exec && out_free_w;
   assign full_w     = (count_ff == '0);
   assign alloc_idx_w = IDX_W'(count_ff - CNT_W'(1));
   assign rd_addr_w  = ctl_cmd.lookup ? hit_idx_w : hit_idx_ff;
   assign rd_pins_w  = rd_data_w[PIN_BITS-1:0];
   assign rd_dirty_w = rd_data_w[PIN_BITS];
   assign dp_stat.out_free = out_free_w;

   always_comb begin
      hit_idx_w = '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         match_w[i] = valid_ff[i] && (page_ff[i] == key_w);
         if (match_w[i]) begin
            hit_idx_w = hit_idx_w | IDX_W'(i);
         end
      end
   end

   always_comb begin
      alloc_w    = 1'b0;
      inval_w    = '0;
      wr_en_w    = 1'b0;
      wr_addr_w  = hit_idx_ff;
      wr_data_w  = rd_data_w;
      new_pins_w = rd_pins_w;
      rsp_w.status      = STAT_OK;
      rsp_w.frame_index = hit_ff ? 4'(hit_idx_ff) : 4'd0;
      rsp_w.result_page = req_ff.page_id;
      rsp_w.pin_value   = hit_ff ? 16'(rd_pins_w) : 16'd0;
      rsp_w.resident    = hit_ff;
      rsp_w.disk_read   = 1'b0;
      rsp_w.disk_write  = 1'b0;
      case (req_ff.cmd)
         CMD_FETCH: begin
            if (hit_ff) begin
               if (rd_pins_w != '1) begin
                  new_pins_w = rd_pins_w + PIN_BITS'(1);
               end
               wr_en_w         = 1'b1;
               wr_data_w       = {rd_dirty_w, new_pins_w};
               rsp_w.pin_value = 16'(new_pins_w);
            end else if (full_w) begin
               rsp_w.status = STAT_FULL;
            end else begin
               rsp_w.disk_read = 1'b1;
               if (!req_ff.io_ok) begin
                  rsp_w.status = STAT_IOERR;
               end else begin
                  alloc_w = 1'b1;
               end
            end
         end
         CMD_NEW: begin
            rsp_w.result_page = '0;
            rsp_w.frame_index = 4'd0;
            rsp_w.pin_value   = 16'd0;
            rsp_w.resident    = 1'b0;
            if (full_w) begin
               rsp_w.status = STAT_FULL;
            end else if (!req_ff.io_ok) begin
               rsp_w.status = STAT_IOERR;
            end else begin
               alloc_w           = 1'b1;
               inval_w           = match_ff;
               rsp_w.result_page = req_ff.new_page_id;
            end
         end
         CMD_UNPIN: begin
            if (!hit_ff) begin
               rsp_w.status = STAT_NOTRES;
            end else if (rd_pins_w == '0) begin
               rsp_w.status = STAT_UNPINNED;
            end else begin
               new_pins_w      = rd_pins_w - PIN_BITS'(1);
               wr_en_w         = 1'b1;
               wr_data_w       = {rd_dirty_w | req_ff.mark_dirty, new_pins_w};
               rsp_w.pin_value = 16'(new_pins_w);
            end
         end
         CMD_FLUSH: begin
            if (!hit_ff) begin
               rsp_w.status = STAT_NOTRES;
            end else if (rd_dirty_w) begin
               rsp_w.disk_write = 1'b1;
               if (req_ff.io_ok) begin
                  wr_en_w   = 1'b1;
                  wr_data_w = {1'b0, rd_pins_w};
               end else begin
                  rsp_w.status = STAT_IOERR;
               end
            end
         end
         default: begin
            rsp_w.status = STAT_OK;
         end
      endcase
      if (alloc_w) begin
         wr_en_w           = 1'b1;
         wr_addr_w         = alloc_idx_w;
         wr_data_w         = {1'b0, PIN_BITS'(1)};
         rsp_w.frame_index = 4'(alloc_idx_w);
         rsp_w.pin_value   = 16'd1;
         rsp_w.resident    = 1'b1;
      end
      wr_en_w = wr_en_w && commit_w;
   end

   always_ff @(posedge clock) begin
      if (ctl_cmd.capture) begin
         req_ff <= req_data;
      end
      if (ctl_cmd.lookup) begin
         match_ff   <= match_w;
         hit_ff     <= |match_w;
         hit_idx_ff <= hit_idx_w;
      end
      if (commit_w) begin
         rsp_ff <= rsp_w;
      end
      for (int i = 0; i < FRAME_COUNT; i++) begin
         if (commit_w && alloc_w && (alloc_idx_w == IDX_W'(i))) begin
            page_ff[i] <= key_w;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= CNT_W'(FRAME_COUNT);
      end else if (commit_w) begin
         for (int i = 0; i < FRAME_COUNT; i++) begin
            if (alloc_w && (alloc_idx_w == IDX_W'(i))) begin
               valid_ff[i] <= 1'b1;
            end else if (inval_w[i]) begin
               valid_ff[i] <= 1'b0;
            end
         end
         if (alloc_w) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit_w) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FRAME_COUNT))
      else $error("free count above frame count");

   a_single_map: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_w))
      else $error("page mapped in more than one frame");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      commit_w |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      !(commit_w && alloc_w) |=> $stable(count_ff))
      else $error("free count moved without allocation");

endmodule
`default_nettype wire

// ===== sv/page_frame_pin_table.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Page frame pin table
// Maps page ids to frames with pin counts, dirty marks and a free-frame count.
// ----------------------------------------------------------------------------
// Each transaction passes the capture, match and execute steps in order, and a new
// request is accepted only once the previous one has left execute; match and update
// are split by the registered read of the pin/dirty RAM.
// A result waiting on rsp_stall holds the execute step until it is taken.
// Reset clears all frame valid bits and sets the free count to FRAME_COUNT.
// ----------------------------------------------------------------------------
module page_frame_pin_table #(
   parameter int FRAME_COUNT = pfpt_pkg::FRAME_COUNT_DEF,
   parameter int PIN_BITS    = pfpt_pkg::PIN_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire pfpt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output pfpt_pkg::rsp_type      rsp_data
);
   import pfpt_pkg::*;

   ctrl_cmd_type ctl_cmd;
   dp_stat_type  dp_stat;

   pfpt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .dp_stat   (dp_stat),
      .ctl_cmd   (ctl_cmd)
   );

   pfpt_dp #(
      .FRAME_COUNT (FRAME_COUNT),
      .PIN_BITS    (PIN_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .ctl_cmd   (ctl_cmd),
      .dp_stat   (dp_stat),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire
